### rtl/core/sha256_stream_hasher_top_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the streaming SHA-256 hasher
// Shared concurrent check forms.
// ---------------------------------------------------------------------------
`ifndef SHA256_STREAM_HASHER_TOP_ASSERT_SVH
`define SHA256_STREAM_HASHER_TOP_ASSERT_SVH

// Implication check under reset.
`define SHA_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication check under reset.
`define SHA_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/sha_pkg.sv
// ---------------------------------------------------------------------------
// SHA-256 hasher package
// Round constants, initial values, queue entry type and round helpers.
// ---------------------------------------------------------------------------
package sha_pkg;

  localparam int unsigned QueueDepth = 4;

  typedef struct packed {
    logic [7:0] data;
    logic       present;
    logic       last;
  } item_t;

  function automatic logic [31:0] round_k(input logic [5:0] idx);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    return k[idx];
  endfunction

  function automatic logic [31:0] init_h(input logic [2:0] idx);
    logic [31:0] h [8];
    h = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
          32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    return h[idx];
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

### rtl/core/sha_queue.sv
// ---------------------------------------------------------------------------
// SHA-256 item queue
// Short FIFO that decouples the input side from the compression engine.
// ---------------------------------------------------------------------------
module sha_queue #(
  parameter int unsigned Depth = sha_pkg::QueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  sha_pkg::item_t push_item_i,
  output logic           full_o,
  input  logic           pop_i,
  output sha_pkg::item_t pop_item_o,
  output logic           empty_o
);
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  sha_pkg::item_t        mem_q [Depth];
  logic [AW-1:0]         wr_q, wr_d, rd_q, rd_d;
  logic [AW:0]           cnt_q, cnt_d;

  assign full_o     = (cnt_q == (AW+1)'(Depth));
  assign empty_o    = (cnt_q == '0);
  assign pop_item_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == AW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == AW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_item_i;
    end
  end
endmodule

### rtl/core/sha_engine.sv
// ---------------------------------------------------------------------------
// SHA-256 compression engine
// Absorbs bytes, pads, runs one round per cycle and emits the digest.
// ---------------------------------------------------------------------------
module sha_engine (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           item_valid_i,
  input  sha_pkg::item_t item_i,
  output logic           item_pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [31:0]    digest_word_o,
  output logic [2:0]     word_index_o,
  output logic           digest_last_o
);
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StComp = 3'd1;
  localparam logic [2:0] StPad  = 3'd2;
  localparam logic [2:0] StEmit = 3'd3;

  logic [2:0]  state_q;
  logic [5:0]  cnt_q;
  logic [63:0] bits_q;
  logic [31:0] h_q [8];
  logic [31:0] v_q [8];
  logic [31:0] w_q [16];
  logic [5:0]  rnd_q;
  logic        pend_end_q;
  logic        pad2_q;
  logic        len_blk_q;
  logic [2:0]  oidx_q;

  logic [31:0] t1, t2, s0, s1, wnew, e, a, wcur;
  logic [7:0]  pad_byte;

  assign e    = v_q[4];
  assign a    = v_q[0];
  assign wcur = w_q[0];
  assign t1 = v_q[7] + (sha_pkg::rotr(e, 6) ^ sha_pkg::rotr(e, 11) ^ sha_pkg::rotr(e, 25))
            + ((e & v_q[5]) ^ (~e & v_q[6])) + sha_pkg::round_k(rnd_q) + wcur;
  assign t2 = (sha_pkg::rotr(a, 2) ^ sha_pkg::rotr(a, 13) ^ sha_pkg::rotr(a, 22))
            + ((a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]));
  assign s0 = sha_pkg::rotr(w_q[1], 7) ^ sha_pkg::rotr(w_q[1], 18) ^ (w_q[1] >> 3);
  assign s1 = sha_pkg::rotr(w_q[14], 17) ^ sha_pkg::rotr(w_q[14], 19) ^ (w_q[14] >> 10);
  assign wnew = s1 + w_q[9] + s0 + w_q[0];

  assign item_pop_o    = (state_q == StIdle) && item_valid_i;
  assign out_valid_o   = (state_q == StEmit);
  assign digest_word_o = h_q[oidx_q];
  assign word_index_o  = oidx_q;
  assign digest_last_o = (oidx_q == 3'd7);

  // Padding byte: marker first, zeros, then the length in the last eight slots
  // of the block that closes the message.
  always_comb begin
    if (!pad2_q) begin
      pad_byte = 8'h80;
    end else if (len_blk_q && cnt_q >= 6'd56) begin
      pad_byte = bits_q[8*(7 - cnt_q[2:0]) +: 8];
    end else begin
      pad_byte = 8'h00;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      cnt_q      <= '0;
      bits_q     <= '0;
      rnd_q      <= '0;
      pend_end_q <= 1'b0;
      pad2_q     <= 1'b0;
      len_blk_q  <= 1'b0;
      oidx_q     <= '0;
      for (int i = 0; i < 8; i++) begin
        h_q[i] <= sha_pkg::init_h(3'(i));
      end
    end else begin
      case (state_q)
        StIdle: begin
          if (item_valid_i) begin
            if (item_i.present) begin
              if (cnt_q[1:0] == 2'd0) begin
                for (int i = 0; i < 15; i++) begin
                  w_q[i] <= w_q[i+1];
                end
              end
              w_q[15] <= {w_q[15][23:0], item_i.data};
              cnt_q <= cnt_q + 1'b1;
              if (cnt_q == 6'd63) begin
                state_q    <= StComp;
                rnd_q      <= '0;
                pend_end_q <= item_i.last;
                bits_q     <= bits_q + 64'd512;
                for (int i = 0; i < 8; i++) begin
                  v_q[i] <= h_q[i];
                end
              end else if (item_i.last) begin
                state_q <= StPad;
              end
            end else if (item_i.last) begin
              state_q <= StPad;
            end
          end
        end
        StPad: begin
          // One byte of padding per cycle into the word shifter.
          if (cnt_q[1:0] == 2'd0) begin
            for (int i = 0; i < 15; i++) begin
              w_q[i] <= w_q[i+1];
            end
          end
          w_q[15] <= {w_q[15][23:0], pad_byte};
          cnt_q <= cnt_q + 1'b1;
          if (!pad2_q) begin
            pad2_q    <= 1'b1;
            len_blk_q <= (cnt_q < 6'd56);
            bits_q    <= bits_q + {55'd0, cnt_q, 3'd0};
          end
          if (cnt_q == 6'd63) begin
            state_q <= StComp;
            rnd_q   <= '0;
            for (int i = 0; i < 8; i++) begin
              v_q[i] <= h_q[i];
            end
          end
        end
        StComp: begin
          for (int i = 0; i < 15; i++) begin
            w_q[i] <= w_q[i+1];
          end
          w_q[15] <= wnew;
          v_q[7] <= v_q[6];
          v_q[6] <= v_q[5];
          v_q[5] <= v_q[4];
          v_q[4] <= v_q[3] + t1;
          v_q[3] <= v_q[2];
          v_q[2] <= v_q[1];
          v_q[1] <= v_q[0];
          v_q[0] <= t1 + t2;
          rnd_q  <= rnd_q + 1'b1;
          if (rnd_q == 6'd63) begin
            h_q[0] <= h_q[0] + t1 + t2;
            h_q[1] <= h_q[1] + v_q[0];
            h_q[2] <= h_q[2] + v_q[1];
            h_q[3] <= h_q[3] + v_q[2];
            h_q[4] <= h_q[4] + v_q[3] + t1;
            h_q[5] <= h_q[5] + v_q[4];
            h_q[6] <= h_q[6] + v_q[5];
            h_q[7] <= h_q[7] + v_q[6];
            if (pad2_q) begin
              if (len_blk_q) begin
                state_q <= StEmit;
              end else begin
                state_q   <= StPad;
                len_blk_q <= 1'b1;
              end
            end else begin
              state_q <= pend_end_q ? StPad : StIdle;
            end
            pend_end_q <= 1'b0;
          end
        end
        StEmit: begin
          if (out_ready_i) begin
            oidx_q <= oidx_q + 1'b1;
            if (oidx_q == 3'd7) begin
              state_q   <= StIdle;
              cnt_q     <= '0;
              bits_q    <= '0;
              pad2_q    <= 1'b0;
              len_blk_q <= 1'b0;
              for (int i = 0; i < 8; i++) begin
                h_q[i] <= sha_pkg::init_h(3'(i));
              end
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end
endmodule

### rtl/core/sha256_stream_hasher_top.sv
// ---------------------------------------------------------------------------
// Streaming SHA-256 hasher, top level
// Queue-fed compression engine producing eight digest words per message.
// ---------------------------------------------------------------------------
// Channel  | Direction | tdata fields (low bit up)            | tuser / tlast
// s_axis   | in        | data_byte[7:0], byte_present[8]      | tlast: message_end
// m_axis   | out       | digest_word[31:0], word_index[34:32] | tlast: digest_last
//
// The engine takes bytes from the queue only while idle; each full block is then
// compressed before more are taken. Closing a message costs padding, the final
// compression and eight output transfers. Back-pressure on the output stalls
// the engine; the input queue keeps accepting until it fills.
// Reset empties the queue and loads the initial hash values.
module sha256_stream_hasher_top #(
  parameter int unsigned QueueDepth = sha_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // data_byte, byte_present
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // digest_word, word_index
  output logic        m_axis_tlast
);
  `include "sha256_stream_hasher_top_assert.svh"

  sha_pkg::item_t in_item, q_item;
  logic full, empty, pop;
  logic [31:0] dw;
  logic [2:0]  wi;
  logic        dl;

  assign in_item.data    = s_axis_tdata[7:0];
  assign in_item.present = s_axis_tdata[8];
  assign in_item.last    = s_axis_tlast;
  assign s_axis_tready   = !full;

  sha_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i, .rst_ni,
    .push_i(s_axis_tvalid && !full), .push_item_i(in_item), .full_o(full),
    .pop_i(pop), .pop_item_o(q_item), .empty_o(empty)
  );

  sha_engine u_engine (
    .clk_i, .rst_ni,
    .item_valid_i(!empty), .item_i(q_item), .item_pop_o(pop),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .digest_word_o(dw), .word_index_o(wi), .digest_last_o(dl)
  );

  assign m_axis_tdata = {5'd0, wi, dw};
  assign m_axis_tlast = dl;

  `SHA_ASSERT_IMP(a_no_pop_empty, clk_i, rst_ni, pop, !empty, "pop from empty queue")
  `SHA_ASSERT_IMP(a_last_idx, clk_i, rst_ni, m_axis_tvalid && m_axis_tlast, wi == 3'd7,
    "last flag off index seven")
endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Testbench for the streaming SHA-256 hasher
// Streams byte messages through the slave channel, computes the digest of
// each message in a behavioral SHA-256 and checks every digest word on the
// master channel in order. Both sides pause at random.
// ---------------------------------------------------------------------------
module tb;

  typedef struct {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       message_end;
  } byte_item_t;

  typedef struct {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        digest_last;
  } digest_out_t;

  localparam int unsigned CycleLimit = 400000;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;

  byte_item_t  pending_items[$];
  digest_out_t expected_words[$];
  logic [7:0]  msg_block[64];
  logic [31:0] hash_state[8];
  int unsigned block_fill;
  logic [63:0] done_bits;
  int unsigned error_count;
  int unsigned cycle_count;
  int unsigned send_wait;
  int unsigned recv_wait;
  int unsigned hold_off;
  bit          stimulus_done;

  sha256_stream_hasher_top i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic logic [31:0] ror(logic [31:0] x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void load_iv();
    hash_state[0] = 32'h6a09e667; hash_state[1] = 32'hbb67ae85;
    hash_state[2] = 32'h3c6ef372; hash_state[3] = 32'ha54ff53a;
    hash_state[4] = 32'h510e527f; hash_state[5] = 32'h9b05688c;
    hash_state[6] = 32'h1f83d9ab; hash_state[7] = 32'h5be0cd19;
    block_fill = 0;
    done_bits = '0;
  endfunction

  function automatic void compress();
    logic [31:0] kc[64];
    logic [31:0] w[64];
    logic [31:0] v[8];
    logic [31:0] t1;
    logic [31:0] t2;
    kc = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    for (int i = 0; i < 16; i++) begin
      w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
    end
    for (int i = 16; i < 64; i++) begin
      w[i] = (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
           + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
    end
    for (int i = 0; i < 8; i++) v[i] = hash_state[i];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + kc[i] + w[i];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_state[i] += v[i];
  endfunction

  function automatic void absorb_item(byte_item_t it);
    int unsigned pos;
    logic [63:0] total;
    digest_out_t dw;
    if (it.byte_present) begin
      msg_block[block_fill] = it.data_byte;
      block_fill++;
      if (block_fill == 64) begin
        compress();
        done_bits += 64'd512;
        block_fill = 0;
      end
    end
    if (!it.message_end) return;
    pos = block_fill;
    total = done_bits + 64'(pos) * 64'd8;
    msg_block[pos] = 8'h80;
    pos++;
    if (pos > 56) begin
      while (pos < 64) begin
        msg_block[pos] = 8'h00;
        pos++;
      end
      compress();
      pos = 0;
    end
    while (pos < 56) begin
      msg_block[pos] = 8'h00;
      pos++;
    end
    for (int i = 0; i < 8; i++) msg_block[56+i] = total[63-8*i -: 8];
    compress();
    for (int i = 0; i < 8; i++) begin
      dw.digest_word = hash_state[i];
      dw.word_index  = 3'(i);
      dw.digest_last = (i == 7);
      expected_words.push_back(dw);
    end
    load_iv();
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    error_count++;
  endtask

  function automatic void add_item(logic [7:0] b, logic p, logic e);
    byte_item_t it;
    it.data_byte = b;
    it.byte_present = p;
    it.message_end = e;
    pending_items.push_back(it);
  endfunction

  function automatic void add_message(int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) add_item(8'($urandom), 1'b0, 1'b0);
      add_item(8'($urandom), 1'b1, 1'b0);
    end
    if ($urandom_range(0, 1)) add_item(8'($urandom), 1'b1, 1'b1);
    else add_item(8'($urandom), 1'b0, 1'b1);
  endfunction

  initial begin
    int unsigned len;
    rst_ni = 1'b0;
    error_count = 0;
    stimulus_done = 0;
    load_iv();
    // Empty message, idle items, extreme bytes, end with a byte.
    add_item(8'hff, 1'b0, 1'b0);
    add_item(8'h00, 1'b0, 1'b1);
    add_item(8'h00, 1'b1, 1'b0);
    add_item(8'hff, 1'b1, 1'b0);
    add_item(8'haa, 1'b0, 1'b0);
    add_item(8'h55, 1'b1, 1'b1);
    add_item(8'hff, 1'b1, 1'b1);
    // Padding boundaries: 54 or 55, 55 or 56, 63 or 64, 64 or 65 bytes.
    add_message(54);
    add_message(55);
    add_message(63);
    add_message(64);
    for (int k = 0; k < 9; k++) add_item(8'($urandom), 1'b1, 1'b0);
    add_item(8'h00, 1'b0, 1'b1);
    while (pending_items.size() < 450) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 130) : $urandom_range(0, 20);
      if ($urandom_range(0, 9) == 0) add_item(8'($urandom), 1'b0, 1'b0);
      add_message(len);
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_items.size() == 0 && !s_axis_tvalid);
    wait (expected_words.size() == 0);
    repeat (200) @(posedge clk_i);
    stimulus_done = 1;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tlast  <= 1'b0;
      send_wait     <= $urandom_range(0, 12);
    end else begin
      if (s_axis_tvalid && s_axis_tready) absorb_item(pending_items.pop_front());
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_items.size() > (s_axis_tvalid && s_axis_tready ? 0 : 0) &&
            (send_wait == 0 || pending_items.size() > 400)) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {7'd0, pending_items[0].byte_present, pending_items[0].data_byte};
          s_axis_tlast  <= pending_items[0].message_end;
          send_wait     <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 12);
        end else begin
          s_axis_tvalid <= 1'b0;
          if (send_wait > 0) send_wait <= send_wait - 1;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    digest_out_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      recv_wait     <= 0;
      hold_off      <= 3000;
      cycle_count   <= 0;
    end else begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
        $display("== FAIL ==");
        $finish;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_words.size() == 0) begin
          report("unexpected word", m_axis_tdata, 0);
        end else begin
          want = expected_words.pop_front();
          if (m_axis_tdata[31:0] !== want.digest_word)
            report("digest_word", m_axis_tdata[31:0], want.digest_word);
          if (m_axis_tdata[34:32] !== want.word_index)
            report("word_index", m_axis_tdata[34:32], want.word_index);
          if (m_axis_tlast !== want.digest_last)
            report("digest_last", m_axis_tlast, want.digest_last);
        end
      end
      if (hold_off > 0 && cycle_count > 2000) begin
        hold_off      <= hold_off - 1;
        m_axis_tready <= 1'b0;
      end else if (recv_wait > 0) begin
        recv_wait     <= recv_wait - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (m_axis_tvalid && m_axis_tready)
          recv_wait <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 12);
      end
    end
  end

  always @(posedge clk_i) begin
    if (stimulus_done) begin
      if (error_count == 0 && expected_words.size() == 0) begin
        $display("== PASS ==");
      end else begin
        $display("== FAIL ==");
      end
      $finish;
    end
  end

endmodule
